@@ rtl/pdwt_pkg.sv @@
package pdwt_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QXY,
        ST_QWZ,
        ST_QYY,
        ST_QZZ,
        ST_AXX,
        ST_AYY,
        ST_RUN,
        ST_WAIT,
        ST_TURN,
        ST_SUM
    } state_t;

    // cordic datapath width, holds the Q28 operands plus gain
    localparam int CW = 40;
    localparam int ZW = 32;
    localparam int ANGLE_TABLE_LEN = 24;

    localparam logic signed [16:0] PI_Q13 = 17'sd25736;
    localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;
    localparam logic signed [ZW-1:0] HALF_PI_Q24 = 32'sd26353589;
    localparam logic signed [ZW-1:0] PI_Q13_Z = 32'sd25736;
    localparam logic signed [CW-1:0] ONE_Q28 = 40'sd268435456;
    localparam logic [23:0] HALF_TRACK_RESET = 24'd13107;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 32'sd13176795;
            5'd1:    v = 32'sd7778716;
            5'd2:    v = 32'sd4110060;
            5'd3:    v = 32'sd2086331;
            5'd4:    v = 32'sd1047214;
            5'd5:    v = 32'sd524117;
            5'd6:    v = 32'sd262123;
            5'd7:    v = 32'sd131069;
            5'd8:    v = 32'sd65536;
            5'd9:    v = 32'sd32768;
            5'd10:   v = 32'sd16384;
            5'd11:   v = 32'sd8192;
            5'd12:   v = 32'sd4096;
            5'd13:   v = 32'sd2048;
            5'd14:   v = 32'sd1024;
            5'd15:   v = 32'sd512;
            5'd16:   v = 32'sd256;
            5'd17:   v = 32'sd128;
            5'd18:   v = 32'sd64;
            5'd19:   v = 32'sd32;
            5'd20:   v = 32'sd16;
            5'd21:   v = 32'sd8;
            5'd22:   v = 32'sd4;
            5'd23:   v = 32'sd2;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/pdwt_if.sv @@
interface pdwt_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z,
                    input ready);
    modport sink (input valid, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z,
                  output ready);
endinterface

interface pdwt_travel_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] right_travel;
    logic signed [31:0] left_travel;

    modport source (output valid, right_travel, left_travel, input ready);
    modport sink (input valid, right_travel, left_travel, output ready);
endinterface

@@ rtl/pdwt_cordic.sv @@
module pdwt_cordic #(
    parameter int STEPS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pdwt_pkg::unit_ctl_t            ctl_in,
    output pdwt_pkg::unit_ctl_t            ctl_out,
    input  logic signed [pdwt_pkg::CW-1:0] x0,
    input  logic signed [pdwt_pkg::CW-1:0] y0,
    output logic signed [15:0]             angle
);
    localparam int IW = $clog2(STEPS + 1);

    logic signed [pdwt_pkg::CW-1:0] x_reg, x_next;
    logic signed [pdwt_pkg::CW-1:0] y_reg, y_next;
    logic signed [pdwt_pkg::ZW-1:0] z_reg, z_next;
    logic [IW-1:0]                  i_reg;
    logic                           run_reg;
    logic                           fin_reg;
    logic                           done_reg;
    logic signed [15:0]             angle_reg;
    logic signed [pdwt_pkg::CW-1:0] xs, ys;
    logic signed [pdwt_pkg::ZW-1:0] step_angle;
    logic signed [pdwt_pkg::ZW-1:0] z_round;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign step_angle = pdwt_pkg::atan_q24(5'(i_reg));
    assign z_round = (z_reg + 32'sd1024) >>> 11;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (ctl_in.start)
        begin
            x_next = x0;
            y_next = y0;
            z_next = '0;
            // left half plane: rotate by a quarter turn first
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    x_next = y0;
                    y_next = -x0;
                    z_next = pdwt_pkg::HALF_PI_Q24;
                end
                else
                begin
                    x_next = -y0;
                    y_next = x0;
                    z_next = -pdwt_pkg::HALF_PI_Q24;
                end
            end
        end
        else if (run_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step_angle;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step_angle;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg     <= '0;
            run_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
            angle_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (ctl_in.start)
            begin
                i_reg <= '0;
                if (x0 == 0 && y0 == 0)
                begin
                    angle_reg <= '0;
                    done_reg  <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(STEPS - 1))
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                if (z_round > pdwt_pkg::PI_Q13_Z)
                    angle_reg <= 16'(pdwt_pkg::PI_Q13_Z);
                else if (z_round < -pdwt_pkg::PI_Q13_Z)
                    angle_reg <= 16'(-pdwt_pkg::PI_Q13_Z);
                else
                    angle_reg <= z_round[15:0];
                done_reg <= 1'b1;
            end
        end
    end

    assign ctl_out.start = run_reg;
    assign ctl_out.done  = done_reg;
    assign angle = angle_reg;

endmodule

@@ rtl/pdwt_isqrt.sv @@
module pdwt_isqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  pdwt_pkg::unit_ctl_t ctl_in,
    output pdwt_pkg::unit_ctl_t ctl_out,
    input  logic [63:0]         radicand,
    output logic [32:0]         root
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg;
    logic        run_reg;
    logic        fin_reg;
    logic        done_reg;
    logic [32:0] root_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        rem_next = rem_reg;
        res_next = res_reg;
        if (ctl_in.start)
        begin
            rem_next = radicand;
            res_next = '0;
        end
        else if (run_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= '0;
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (ctl_in.start)
            begin
                bit_reg <= 64'h4000_0000_0000_0000;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                // round to nearest
                root_reg <= res_reg[32:0] + 33'(rem_reg > res_reg);
                done_reg <= 1'b1;
            end
        end
    end

    assign ctl_out.start = run_reg;
    assign ctl_out.done  = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/pose_delta_to_wheel_travel_top.sv @@
// channel   dir  handshake      payload
// pose      in   valid/ready    pos_x, pos_y, quat_w, quat_x, quat_y, quat_z
// travel    out  valid/ready    right_travel, left_travel
// half_trk  in   we only        half_track_data
//
// after a pose transfer the block stays busy until its result is registered; the
// result is offered in the same cycle as the next ready. the 32-step square root
// runs beside the cordic; both start when the block enters the run state
// one shared 33x33 multiplier serves the yaw terms, squares and turn product
// rst_n clears the previous pose to zero and half_track to its default
// a stalled result holds in the output register; pose.ready stays low until
// the block is back in idle
module pose_delta_to_wheel_travel_top #(
    parameter int ROTATION_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    pdwt_pose_if.sink   pose,
    pdwt_travel_if.source travel,
    input  logic        half_track_we,
    input  logic [23:0] half_track_data
);
    pdwt_pkg::state_t state_reg, state_next;

    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [31:0] last_x_reg, last_y_reg;
    logic signed [15:0] last_head_reg, head_reg;
    logic [23:0]        half_track_reg;
    logic signed [65:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [pdwt_pkg::CW-1:0] cx_reg, cy_reg;
    logic [31:0]        ax_reg, ay_reg;
    logic               big_reg;
    logic [33:0]        ds_reg;
    logic               c_flag_reg, s_flag_reg;
    logic signed [31:0] right_reg, left_reg;
    logic               out_valid_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [32:0] dx, dy, adx, ady, hx, hy;
    logic               big;
    logic signed [16:0] dphi_raw, dphi;
    logic signed [47:0] turn, sum_r, sum_l;
    logic               out_free;
    logic               run_start;
    logic               c_ok, s_ok;

    pdwt_pkg::unit_ctl_t c_in, c_out, s_in, s_out;
    logic signed [15:0]  angle;
    logic [32:0]         root;
    logic [63:0]         radicand;

    assign run_start = (state_reg == pdwt_pkg::ST_RUN);
    assign c_in.start = run_start;
    assign c_in.done  = 1'b0;
    assign s_in.start = run_start;
    assign s_in.done  = 1'b0;
    assign radicand = 64'(acc_reg + 64'(prod_reg));

    pdwt_cordic #(.STEPS(ROTATION_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (c_in),
        .ctl_out (c_out),
        .x0      (cx_reg),
        .y0      (cy_reg),
        .angle   (angle)
    );

    pdwt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (s_in),
        .ctl_out  (s_out),
        .radicand (radicand),
        .root     (root)
    );

    // position deltas, halved when too large for the square root
    assign dx  = 33'(px_reg) - 33'(last_x_reg);
    assign dy  = 33'(py_reg) - 33'(last_y_reg);
    assign adx = dx[32] ? -dx : dx;
    assign ady = dy[32] ? -dy : dy;
    assign big = adx[32] | adx[31] | ady[32] | ady[31];
    assign hx  = dx >>> 1;
    assign hy  = dy >>> 1;

    assign dphi_raw = 17'(head_reg) - 17'(last_head_reg);
    always_comb
    begin
        if (dphi_raw < -pdwt_pkg::PI_Q13)
            dphi = dphi_raw + pdwt_pkg::TWO_PI_Q13;
        else if (dphi_raw > pdwt_pkg::PI_Q13)
            dphi = dphi_raw - pdwt_pkg::TWO_PI_Q13;
        else
            dphi = dphi_raw;
    end

    assign turn  = 48'((prod_reg + 66'sd4096) >>> 13);
    assign sum_r = 48'($signed({1'b0, ds_reg})) + turn;
    assign sum_l = 48'($signed({1'b0, ds_reg})) - turn;

    assign out_free = !out_valid_reg || travel.ready;
    assign c_ok = c_flag_reg || c_out.done;
    assign s_ok = s_flag_reg || s_out.done;

    always_comb
    begin
        state_next = state_reg;
        mul_a = 33'(qx_reg);
        mul_b = 33'(qy_reg);
        case (state_reg)
            pdwt_pkg::ST_IDLE:
            begin
                if (pose.valid)
                    state_next = pdwt_pkg::ST_QXY;
            end
            pdwt_pkg::ST_QXY:
                state_next = pdwt_pkg::ST_QWZ;
            pdwt_pkg::ST_QWZ:
            begin
                mul_a = 33'(qw_reg);
                mul_b = 33'(qz_reg);
                state_next = pdwt_pkg::ST_QYY;
            end
            pdwt_pkg::ST_QYY:
            begin
                mul_a = 33'(qy_reg);
                mul_b = 33'(qy_reg);
                state_next = pdwt_pkg::ST_QZZ;
            end
            pdwt_pkg::ST_QZZ:
            begin
                mul_a = 33'(qz_reg);
                mul_b = 33'(qz_reg);
                state_next = pdwt_pkg::ST_AXX;
            end
            pdwt_pkg::ST_AXX:
            begin
                mul_a = $signed({1'b0, ax_reg});
                mul_b = $signed({1'b0, ax_reg});
                state_next = pdwt_pkg::ST_AYY;
            end
            pdwt_pkg::ST_AYY:
            begin
                mul_a = $signed({1'b0, ay_reg});
                mul_b = $signed({1'b0, ay_reg});
                state_next = pdwt_pkg::ST_RUN;
            end
            pdwt_pkg::ST_RUN:
                state_next = pdwt_pkg::ST_WAIT;
            pdwt_pkg::ST_WAIT:
            begin
                if (c_ok && s_ok)
                    state_next = pdwt_pkg::ST_TURN;
            end
            pdwt_pkg::ST_TURN:
            begin
                mul_a = $signed({9'b0, half_track_reg});
                mul_b = 33'(dphi);
                state_next = pdwt_pkg::ST_SUM;
            end
            pdwt_pkg::ST_SUM:
            begin
                mul_a = $signed({9'b0, half_track_reg});
                mul_b = 33'(dphi);
                if (out_free)
                    state_next = pdwt_pkg::ST_IDLE;
            end
            default:
                state_next = pdwt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pdwt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            pdwt_pkg::ST_IDLE:
            begin
                px_reg <= pose.pos_x;
                py_reg <= pose.pos_y;
                qw_reg <= pose.quat_w;
                qx_reg <= pose.quat_x;
                qy_reg <= pose.quat_y;
                qz_reg <= pose.quat_z;
            end
            pdwt_pkg::ST_QXY:
            begin
                big_reg <= big;
                ax_reg  <= big ? (hx[32] ? 32'(-hx) : 32'(hx)) : adx[31:0];
                ay_reg  <= big ? (hy[32] ? 32'(-hy) : 32'(hy)) : ady[31:0];
            end
            pdwt_pkg::ST_QWZ:
                acc_reg <= 64'(prod_reg);
            pdwt_pkg::ST_QYY:
                cy_reg <= pdwt_pkg::CW'((acc_reg + 64'(prod_reg)) <<< 1);
            pdwt_pkg::ST_QZZ:
                acc_reg <= 64'(prod_reg);
            pdwt_pkg::ST_AXX:
                cx_reg <= pdwt_pkg::ONE_Q28
                          - pdwt_pkg::CW'((acc_reg + 64'(prod_reg)) <<< 1);
            pdwt_pkg::ST_AYY:
                acc_reg <= 64'(prod_reg);
            default:
            begin
            end
        endcase
        if (c_out.done)
            head_reg <= angle;
        if (s_out.done)
            ds_reg <= big_reg ? {root, 1'b0} : {1'b0, root};
        if (state_reg == pdwt_pkg::ST_SUM && out_free)
        begin
            if (sum_r > 48'sd2147483647)
                right_reg <= 32'sh7fffffff;
            else if (sum_r < -48'sd2147483648)
                right_reg <= 32'sh80000000;
            else
                right_reg <= sum_r[31:0];
            if (sum_l > 48'sd2147483647)
                left_reg <= 32'sh7fffffff;
            else if (sum_l < -48'sd2147483648)
                left_reg <= 32'sh80000000;
            else
                left_reg <= sum_l[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_head_reg  <= '0;
            half_track_reg <= pdwt_pkg::HALF_TRACK_RESET;
            c_flag_reg     <= 1'b0;
            s_flag_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (half_track_we)
                half_track_reg <= half_track_data;
            if (state_reg == pdwt_pkg::ST_WAIT)
            begin
                c_flag_reg <= c_ok && !s_ok;
                s_flag_reg <= s_ok && !c_ok;
            end
            if (state_reg == pdwt_pkg::ST_SUM && out_free)
            begin
                out_valid_reg <= 1'b1;
                last_x_reg    <= px_reg;
                last_y_reg    <= py_reg;
                last_head_reg <= head_reg;
            end
            else if (travel.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign pose.ready = (state_reg == pdwt_pkg::ST_IDLE);
    assign travel.valid = out_valid_reg;
    assign travel.right_travel = right_reg;
    assign travel.left_travel = left_reg;

endmodule

@@ rtl/pdwt_checker.sv @@
module pdwt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] right_travel
);
    // output holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(right_travel))
        else $error("result dropped or changed while stalled");

    // busy right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a new result only comes out of a busy block
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without work in progress");

    // no result in the cycle after an idle accept
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result too early");
endmodule

bind pose_delta_to_wheel_travel_top pdwt_checker u_pdwt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pose.valid),
    .in_ready     (pose.ready),
    .out_valid    (travel.valid),
    .out_ready    (travel.ready),
    .right_travel (travel.right_travel)
);

@@ test/tb.sv @@
module tb;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } pose_t;

    typedef struct {
        logic signed [31:0] right_travel;
        logic signed [31:0] left_travel;
    } travel_t;

    localparam int STEPS = 16;
    localparam int MAX_CYCLES = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic half_track_we = 1'b0;
    logic [23:0] half_track_data = '0;
    logic pose_took = 1'b0;

    pdwt_pose_if   pose_ch();
    pdwt_travel_if travel_ch();

    pose_delta_to_wheel_travel_top #(.ROTATION_STEPS(STEPS)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .pose(pose_ch.sink),
        .travel(travel_ch.source),
        .half_track_we(half_track_we),
        .half_track_data(half_track_data)
    );

    always #5 clk = ~clk;

    pose_t   pose_queue[$];
    travel_t travel_expected[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_off = 0;

    // predictor state
    logic signed [63:0] prev_x = 0;
    logic signed [63:0] prev_y = 0;
    logic signed [63:0] prev_heading = 0;
    logic [23:0]        track_arm = pdwt_pkg::HALF_TRACK_RESET;

    function automatic logic signed [63:0] table_angle(int i);
        logic signed [63:0] t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214,
            524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
        return t[i];
    endfunction

    function automatic logic signed [63:0] heading_of(pose_t p);
        logic signed [63:0] qw, qx, qy, qz, ya, xa, za, tmp, xs, ys;
        qw = p.quat_w;
        qx = p.quat_x;
        qy = p.quat_y;
        qz = p.quat_z;
        ya = 2 * (qx * qy + qw * qz);
        xa = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
        za = 0;
        if (xa == 0 && ya == 0)
        begin
            return 0;
        end
        if (xa < 0)
        begin
            tmp = xa;
            if (ya >= 0)
            begin
                xa = ya;
                ya = -tmp;
                za = 26353589;
            end
            else
            begin
                xa = -ya;
                ya = tmp;
                za = -26353589;
            end
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            xs = xa >>> i;
            ys = ya >>> i;
            if (ya >= 0)
            begin
                xa = xa + ys;
                ya = ya - xs;
                za = za + table_angle(i);
            end
            else
            begin
                xa = xa - ys;
                ya = ya + xs;
                za = za - table_angle(i);
            end
        end
        za = (za + 1024) >>> 11;
        if (za > 25736)
            za = 25736;
        if (za < -25736)
            za = -25736;
        return za;
    endfunction

    function automatic logic [63:0] root_rounded(logic [63:0] s);
        logic [63:0] res, bitv, rem;
        res = 0;
        bitv = 64'd1 << 62;
        rem = s;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        if (rem > res)
            res = res + 1;
        return res;
    endfunction

    function automatic logic signed [31:0] clip32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic travel_t wheel_travel(pose_t p);
        logic signed [63:0] head, dx, dy, dphi, hx, hy, turn, path_len;
        logic [63:0] ax, ay;
        travel_t r;
        head = heading_of(p);
        dx = 64'(p.pos_x) - prev_x;
        dy = 64'(p.pos_y) - prev_y;
        dphi = head - prev_heading;
        if (dphi < -25736)
            dphi = dphi + 51472;
        else if (dphi > 25736)
            dphi = dphi - 51472;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31))
        begin
            hx = dx >>> 1;
            hy = dy >>> 1;
            ax = (hx < 0) ? -hx : hx;
            ay = (hy < 0) ? -hy : hy;
            path_len = root_rounded(ax * ax + ay * ay) * 2;
        end
        else
            path_len = root_rounded(ax * ax + ay * ay);
        turn = ($signed({40'd0, track_arm}) * dphi + 4096) >>> 13;
        r.right_travel = clip32(path_len + turn);
        r.left_travel = clip32(path_len - turn);
        prev_x = p.pos_x;
        prev_y = p.pos_y;
        prev_heading = head;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
        error_count++;
    endtask

    // input transfer seen at the last rising edge
    always @(posedge clk)
        pose_took <= pose_ch.valid && pose_ch.ready;

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            pose_ch.valid <= 1'b0;
        else if (!pose_ch.valid || pose_took)
        begin
            if (pose_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pose_t p;
                p = pose_queue.pop_front();
                pose_ch.valid  <= 1'b1;
                pose_ch.pos_x  <= p.pos_x;
                pose_ch.pos_y  <= p.pos_y;
                pose_ch.quat_w <= p.quat_w;
                pose_ch.quat_x <= p.quat_x;
                pose_ch.quat_y <= p.quat_y;
                pose_ch.quat_z <= p.quat_z;
            end
            else
                pose_ch.valid <= 1'b0;
        end
    end

    // receiver ready
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            travel_ch.ready <= 1'b0;
        end
        else
            travel_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && pose_ch.valid && pose_ch.ready)
        begin
            pose_t p;
            p.pos_x = pose_ch.pos_x;
            p.pos_y = pose_ch.pos_y;
            p.quat_w = pose_ch.quat_w;
            p.quat_x = pose_ch.quat_x;
            p.quat_y = pose_ch.quat_y;
            p.quat_z = pose_ch.quat_z;
            travel_expected.push_back(wheel_travel(p));
        end
        if (rst_n && travel_ch.valid && travel_ch.ready)
        begin
            travel_t w;
            if (travel_expected.size() == 0)
                report_mismatch("unexpected travel", travel_ch.right_travel, '0);
            else
            begin
                w = travel_expected.pop_front();
                if (travel_ch.right_travel !== w.right_travel)
                    report_mismatch("right_travel", travel_ch.right_travel, w.right_travel);
                if (travel_ch.left_travel !== w.left_travel)
                    report_mismatch("left_travel", travel_ch.left_travel, w.left_travel);
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("timeout");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(3))
            0: return 16'($urandom_range(32768) - 16384);
            1: return 16'($urandom);
            default: return 16'($urandom_range(200) - 100);
        endcase
    endfunction

    function automatic pose_t random_pose(logic signed [31:0] px, logic signed [31:0] py);
        pose_t p;
        int k;
        k = $urandom_range(9);
        // wide jumps cover the halving path and saturation
        if (k == 0)
        begin
            p.pos_x = $urandom;
            p.pos_y = $urandom;
        end
        else
        begin
            p.pos_x = px + 32'($signed($urandom_range(131072)) - 65536);
            p.pos_y = py + 32'($signed($urandom_range(131072)) - 65536);
        end
        if ($urandom_range(3) != 0)
        begin
            // planar yaw-only quaternion, w and z drawn independently, not normalised
            p.quat_x = 0;
            p.quat_y = 0;
            p.quat_w = 16'($urandom_range(32768) - 16384);
            p.quat_z = 16'($urandom_range(32768) - 16384);
        end
        else
        begin
            p.quat_w = rand_quat();
            p.quat_x = rand_quat();
            p.quat_y = rand_quat();
            p.quat_z = rand_quat();
        end
        return p;
    endfunction

    function automatic pose_t mk(int px, int py, int qw, int qx, int qy, int qz);
        pose_t p;
        p.pos_x = px;
        p.pos_y = py;
        p.quat_w = qw;
        p.quat_x = qx;
        p.quat_y = qy;
        p.quat_z = qz;
        return p;
    endfunction

    task automatic drain();
        while (pose_queue.size() > 0 || pose_ch.valid || travel_expected.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_track(logic [23:0] v);
        @(negedge clk);
        half_track_we <= 1'b1;
        half_track_data <= v;
        @(negedge clk);
        half_track_we <= 1'b0;
        track_arm = v;
    endtask

    initial
    begin
        logic signed [31:0] lx, ly;
        logic [23:0] tracks[4];
        tracks = '{24'd0, 24'hffffff, 24'd13107, 24'd65536};
        pose_ch.valid = 1'b0;
        pose_ch.pos_x = '0;
        pose_ch.pos_y = '0;
        pose_ch.quat_w = '0;
        pose_ch.quat_x = '0;
        pose_ch.quat_y = '0;
        pose_ch.quat_z = '0;
        travel_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: default arm, extremes and special cases
        pose_queue.push_back(mk(0, 0, 0, 0, 0, 0));
        pose_queue.push_back(mk(65536, 0, 16384, 0, 0, 0));
        pose_queue.push_back(mk(65536, 65536, 0, 0, 0, 16384));
        pose_queue.push_back(mk(0, 0, 0, 0, 0, -16384));
        pose_queue.push_back(mk(0, 0, 11585, 0, 0, 11585));
        pose_queue.push_back(mk(0, 0, 0, 16384, 0, 0));
        pose_queue.push_back(mk(0, 0, -16384, 16384, 16384, -16384));
        pose_queue.push_back(mk(32'h7fffffff, 32'h7fffffff, 16384, 0, 0, 1));
        pose_queue.push_back(mk(32'h80000000, 32'h80000000, 16384, 0, 0, -1));
        pose_queue.push_back(mk(32'h7fffffff, 32'h80000000, -32768, -32768, -32768, -32768));
        pose_queue.push_back(mk(0, 32'h7fffffff, 32767, 32767, 32767, 32767));
        pose_queue.push_back(mk(-1, -1, 0, 0, 16384, 0));
        pose_queue.push_back(mk(1, 1, 1, 1, 1, 1));
        pose_queue.push_back(mk(0, 0, 16384, 0, 0, 0));
        drain();
        write_track(24'hffffff);
        pose_queue.push_back(mk(0, 0, 0, 0, 0, 16384));
        pose_queue.push_back(mk(0, 0, 16384, 0, 0, 0));
        pose_queue.push_back(mk(100, 0, 0, 0, 0, -16384));
        pose_queue.push_back(mk(32'h80000000, 0, 16384, 0, 0, 0));
        drain();
        lx = 0;
        ly = 0;

        for (int ph = 0; ph < 5; ph++)
        begin
            write_track(ph < 4 ? tracks[ph] : 24'($urandom));
            case (ph)
                1: begin send_idle_pct = 62; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 62; end
                3: begin send_idle_pct = 9; recv_stall_pct = 9; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 340; n++)
            begin
                pose_t p;
                p = random_pose(lx, ly);
                lx = p.pos_x;
                ly = p.pos_y;
                pose_queue.push_back(p);
            end
            if (ph == 0)
            begin
                hold_off = 2000;
            end
            drain();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/pdwt_pkg.sv
rtl/pdwt_if.sv
rtl/pdwt_cordic.sv
rtl/pdwt_isqrt.sv
rtl/pose_delta_to_wheel_travel_top.sv
rtl/pdwt_checker.sv
test/tb.sv
